### rtl/core/dcfsa_pkg.sv
package dcfsa_pkg;

    // History per channel and the widths that follow from it
    localparam int HISTORY_DEPTH = 8;
    localparam int POS_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int RING_AW       = POS_W + 1;
    localparam int RING_DEPTH    = 2 ** RING_AW;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 2 * BYTE_W;
    localparam int SUM_W   = CODE_W + POS_W;
    localparam int MASS_W  = 15;
    localparam int STEP_W  = $clog2(SUM_W);

    // Shared multiplier and mass search
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int PLO_W   = MUL_W + CODE_W;
    localparam int POW_W   = 5 * CODE_W;
    localparam int LHS_W   = 56;
    localparam int SHIFT_K = 18;
    localparam logic [MUL_W-1:0] FIVE_POW_11 = 32'd48828125;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CUTOFF  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CUTOFF = 1'b1;
    localparam logic [CODE_W-1:0] LOW_CUTOFF_RESET  = 16'd80;
    localparam logic [CODE_W-1:0] HIGH_CUTOFF_RESET = 16'd26400;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_DIV,
        ST_WINDOW,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_P5,
        ST_SQ,
        ST_SCALE,
        ST_TEST,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               we;
        logic [RING_AW-1:0] waddr;
        logic [CODE_W-1:0]  wdata;
        logic [RING_AW-1:0] raddr;
    } ring_req_t;

endpackage

### rtl/core/dcfsa_if.sv
interface dcfsa_sample_if;
    import dcfsa_pkg::*;

    logic              valid;
    logic              ready;
    logic              channel;
    logic [BYTE_W-1:0] byte_high;
    logic [BYTE_W-1:0] byte_low;

    modport source (output valid, channel, byte_high, byte_low, input ready);
    modport sink   (input valid, channel, byte_high, byte_low, output ready);
endinterface

interface dcfsa_result_if;
    import dcfsa_pkg::*;

    logic              valid;
    logic              ready;
    logic              out_channel;
    logic [CODE_W-1:0] raw_code;
    logic [CODE_W-1:0] average_code;
    logic [MASS_W-1:0] mass_sixtyfourths;
    logic              in_window;

    modport source (output valid, out_channel, raw_code, average_code,
                    mass_sixtyfourths, in_window, input ready);
    modport sink   (input valid, out_channel, raw_code, average_code,
                    mass_sixtyfourths, in_window, output ready);
endinterface

### rtl/core/dcfsa_ring.sv
module dcfsa_ring (
    input  logic                          clk,
    input  dcfsa_pkg::ring_req_t          req,
    output logic [dcfsa_pkg::CODE_W-1:0]  rdata
);
    import dcfsa_pkg::*;

    logic [CODE_W-1:0] mem [RING_DEPTH];

    // One write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

### rtl/core/dcfsa_mul.sv
module dcfsa_mul (
    input  logic                          clk,
    input  logic [dcfsa_pkg::MUL_W-1:0]   op_a,
    input  logic [dcfsa_pkg::MUL_W-1:0]   op_b,
    output logic [dcfsa_pkg::PROD_W-1:0]  prod
);
    import dcfsa_pkg::*;

    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    // Register the product before any further use
    always_ff @(posedge clk)
    begin
        prod <= prod_next;
    end

endmodule

### rtl/core/dual_channel_force_sensor_averager.sv
// Channel   Dir  Handshake      Payload
// samples   in   valid/ready    channel, byte_high, byte_low
// results   out  valid/ready    out_channel, raw_code, average_code,
//                               mass_sixtyfourths, in_window
// cfg       in   cfg_we         cfg_index, cfg_data (no read-back)
//
// After the accepting edge a request reads the channel's N filled entries
// (N is its fill count, 1..HISTORY_DEPTH), divides the sum by N and tests the
// average against the cutoff window; only inside the window does the mass
// search follow. The sequencer is back in idle, ready for the next request, in
// the cycle that the result becomes valid. The sum pass reads the ring
// entry by entry, the divide is one quotient bit per cycle, and the mass
// search settles one bit per square, scale and test on the shared multiplier.
// Reset (rst_n low, asynchronous) clears fill counts, write positions and the
// sequencer, and reloads the cutoffs; the ring itself is never cleared.
// A waiting result sits in the output register and does not block the
// next request; the sequencer holds its finished result only when that
// register is still full.
module dual_channel_force_sensor_averager (
    input  logic                              clk,
    input  logic                              rst_n,
    dcfsa_sample_if.sink                      samples,
    dcfsa_result_if.source                    results,
    input  logic                              cfg_we,
    input  logic [dcfsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcfsa_pkg::CODE_W-1:0]      cfg_data
);
    import dcfsa_pkg::*;

    state_t state_reg, state_next;

    // Per-channel ring bookkeeping
    logic [POS_W-1:0]  pos_reg  [2];
    logic [CNT_W-1:0]  fill_reg [2];

    logic [CODE_W-1:0] low_reg;
    logic [CODE_W-1:0] high_reg;

    // Current request
    logic              ch_reg;
    logic [CODE_W-1:0] code_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  sum_reg;     // sum, then dividend, then quotient
    logic [CNT_W:0]    rem_reg;
    logic              inside_reg;
    logic [MUL_W-1:0]  quad_hi_reg;
    logic [PLO_W-1:0]  plo_reg;
    logic [POW_W-1:0]  pow_reg;
    logic [MASS_W-1:0] mass_reg;

    // Output register
    logic              out_valid_reg;
    logic              out_ch_reg;
    logic [CODE_W-1:0] out_raw_reg;
    logic [CODE_W-1:0] out_avg_reg;
    logic [MASS_W-1:0] out_mass_reg;
    logic              out_win_reg;

    logic              accept;
    logic [CODE_W-1:0] in_code;
    logic [CNT_W-1:0]  fill_cur;
    logic [CNT_W-1:0]  cnt_new;
    logic [POS_W-1:0]  pos_cur;
    logic [POS_W-1:0]  pos_new;
    logic [CNT_W:0]    rem_shift;
    logic              rem_ge;
    logic [CNT_W:0]    rem_sub;
    logic [CODE_W-1:0] avg;
    logic              win;
    logic [MASS_W-1:0] trial;
    logic [POW_W-1:0]  lhs_ext;
    logic              out_free;
    logic              last_entry;

    ring_req_t         ring_req;
    logic [CODE_W-1:0] ring_rdata;
    logic [MUL_W-1:0]  op_a;
    logic [MUL_W-1:0]  op_b;
    logic [PROD_W-1:0] prod;

    dcfsa_ring u_ring (
        .clk   (clk),
        .req   (ring_req),
        .rdata (ring_rdata)
    );

    dcfsa_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign accept   = samples.valid && samples.ready;
    assign in_code  = {samples.byte_high, samples.byte_low};
    assign fill_cur = fill_reg[samples.channel];
    assign pos_cur  = pos_reg[samples.channel];
    assign cnt_new  = (fill_cur == CNT_W'(HISTORY_DEPTH)) ? fill_cur : fill_cur + CNT_W'(1);
    assign pos_new  = (pos_cur == POS_W'(HISTORY_DEPTH - 1)) ? '0 : pos_cur + POS_W'(1);

    // Restoring divide: bring in the next dividend bit, subtract the count if it fits
    assign rem_shift = {rem_reg[CNT_W-1:0], sum_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, cnt_reg});
    assign rem_sub   = rem_shift - {1'b0, cnt_reg};

    assign avg = sum_reg[CODE_W-1:0];
    assign win = (avg > low_reg) && (avg < high_reg);

    // Mass search: keep a bit when trial^2 * 5^11 * 2^18 <= avg^5
    assign trial   = mass_reg | (MASS_W'(1) << step_reg);
    assign lhs_ext = POW_W'({prod[LHS_W-1:0], {SHIFT_K{1'b0}}});

    assign out_free   = !out_valid_reg || results.ready;
    assign last_entry = ((idx_reg + CNT_W'(1)) == cnt_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_READ;
            ST_READ:   state_next = ST_ADD;
            ST_ADD:    state_next = last_entry ? ST_DIV : ST_READ;
            ST_DIV:    if (step_reg == '0) state_next = ST_WINDOW;
            ST_WINDOW: state_next = win ? ST_P1 : ST_FINISH;
            ST_P1:     state_next = ST_P2;
            ST_P2:     state_next = ST_P3;
            ST_P3:     state_next = ST_P4;
            ST_P4:     state_next = ST_P5;
            ST_P5:     state_next = ST_SQ;
            ST_SQ:     state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_TEST;
            ST_TEST:   state_next = (step_reg == '0) ? ST_FINISH : ST_SQ;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: ready, ring request, multiplier operands
    always_comb
    begin
        samples.ready  = (state_reg == ST_IDLE);
        ring_req.we    = accept;
        ring_req.waddr = {samples.channel, pos_cur};
        ring_req.wdata = in_code;
        ring_req.raddr = {ch_reg, idx_reg[POS_W-1:0]};
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_P1:
            begin
                op_a = MUL_W'(avg);
                op_b = MUL_W'(avg);
            end
            ST_P2:
            begin
                op_a = prod[MUL_W-1:0];
                op_b = prod[MUL_W-1:0];
            end
            ST_P3:
            begin
                op_a = prod[MUL_W-1:0];
                op_b = MUL_W'(avg);
            end
            ST_P4:
            begin
                op_a = quad_hi_reg;
                op_b = MUL_W'(avg);
            end
            ST_SQ:
            begin
                op_a = MUL_W'(trial);
                op_b = MUL_W'(trial);
            end
            ST_SCALE:
            begin
                op_a = prod[MUL_W-1:0];
                op_b = FIVE_POW_11;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg[0]    <= '0;
            pos_reg[1]    <= '0;
            fill_reg[0]   <= '0;
            fill_reg[1]   <= '0;
            low_reg       <= LOW_CUTOFF_RESET;
            high_reg      <= HIGH_CUTOFF_RESET;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOW_CUTOFF:  low_reg  <= cfg_data;
                    CFG_HIGH_CUTOFF: high_reg <= cfg_data;
                    default:         low_reg  <= low_reg;
                endcase
            end

            if (accept)
            begin
                pos_reg[samples.channel]  <= pos_new;
                fill_reg[samples.channel] <= cnt_new;
                cnt_reg <= cnt_new;
                idx_reg <= '0;
            end

            case (state_reg)
                ST_ADD:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (last_entry)
                    begin
                        step_reg <= STEP_W'(SUM_W - 1);
                    end
                end
                ST_DIV:  step_reg <= step_reg - STEP_W'(1);
                ST_P5:   step_reg <= STEP_W'(MASS_W - 1);
                ST_TEST: step_reg <= step_reg - STEP_W'(1);
                default: step_reg <= step_reg;
            endcase

            // Load a finished result, drop a delivered one
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg   <= samples.channel;
            code_reg <= in_code;
            sum_reg  <= '0;
            rem_reg  <= '0;
        end

        case (state_reg)
            ST_ADD:
            begin
                sum_reg <= sum_reg + SUM_W'(ring_rdata);
            end
            ST_DIV:
            begin
                rem_reg <= rem_ge ? rem_sub : rem_shift;
                sum_reg <= {sum_reg[SUM_W-2:0], rem_ge};
            end
            ST_WINDOW:
            begin
                inside_reg <= win;
                mass_reg   <= '0;
            end
            ST_P3:
            begin
                quad_hi_reg <= prod[PROD_W-1:MUL_W];
            end
            ST_P4:
            begin
                plo_reg <= prod[PLO_W-1:0];
            end
            ST_P5:
            begin
                pow_reg <= {prod[PLO_W-1:0], {MUL_W{1'b0}}} + POW_W'(plo_reg);
            end
            ST_TEST:
            begin
                if (lhs_ext <= pow_reg)
                begin
                    mass_reg <= trial;
                end
            end
            default:
            begin
                mass_reg <= mass_reg;
            end
        endcase

        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_ch_reg   <= ch_reg;
            out_raw_reg  <= code_reg;
            out_avg_reg  <= avg;
            out_mass_reg <= mass_reg;
            out_win_reg  <= inside_reg;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.out_channel       = out_ch_reg;
    assign results.raw_code          = out_raw_reg;
    assign results.average_code      = out_avg_reg;
    assign results.mass_sixtyfourths = out_mass_reg;
    assign results.in_window         = out_win_reg;

    a_accept_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_READ))
        else $error("accepted request did not start the sum pass");

    a_idx_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_READ) || (state_reg == ST_ADD)) |-> (idx_reg < cnt_reg))
        else $error("ring read beyond filled entries");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> ((cnt_reg != '0) && (cnt_reg <= CNT_W'(HISTORY_DEPTH))))
        else $error("fill count out of range during a request");

    a_mass_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.in_window) |-> (results.mass_sixtyfourths == '0))
        else $error("nonzero mass outside the cutoff window");

    a_result_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && (state_reg != ST_FINISH)) |=> !results.valid)
        else $error("delivered result was not dropped");

endmodule
